FILE: design/tdem_pkg.sv
package tdem_pkg;

  // Fixed-point format: unsigned, FRAC_BITS fraction bits, values below 2^8
  localparam int FRAC_BITS = 24;
  localparam int QW        = FRAC_BITS + 8;
  localparam int PW        = 2 * QW;

  // Port field widths
  localparam int ELEV_W   = 18;
  localparam int SLANT_W  = 19;
  localparam int HEIGHT_W = 15;
  localparam int WET_W    = 14;
  localparam int CFG_W    = 15;

  // Configuration register indexes
  typedef enum logic [0:0] {REG_HEIGHT = 1'b0, REG_WET = 1'b1} cfg_reg_t;

  localparam logic [QW-1:0] ONE_Q   = QW'(1) << FRAC_BITS;
  localparam logic [QW-1:0] THREE_Q = QW'(3) << FRAC_BITS;

  // Constants held with 60 fraction bits, rounded half up to the working format
  localparam logic [63:0] Q60_DRY   = 64'd2651154529058490690;
  localparam logic [63:0] Q60_EXP8  = 64'd16717361816799;
  localparam logic [63:0] Q60_RAD   = 64'd20122276272436;
  localparam logic [63:0] Q60_BIAS  = 64'd2306995930718301;
  localparam logic [63:0] Q60_SCALE = 64'd1154074426111453823;
  localparam int          Q60_SH    = 60 - FRAC_BITS;
  localparam logic [63:0] Q60_HALF  = 64'd1 << (59 - FRAC_BITS);

  localparam logic [QW-1:0] DRY_Q   = QW'((Q60_DRY + Q60_HALF) >> Q60_SH);
  localparam logic [QW-1:0] EXP8_Q  = QW'((Q60_EXP8 + Q60_HALF) >> Q60_SH);
  localparam logic [QW-1:0] RAD_Q   = QW'((Q60_RAD + Q60_HALF) >> Q60_SH);
  localparam logic [QW-1:0] BIAS_Q  = QW'((Q60_BIAS + Q60_HALF) >> Q60_SH);
  localparam logic [QW-1:0] SCALE_Q = QW'((Q60_SCALE + Q60_HALF) >> Q60_SH);

  // Series lengths
  localparam int          SIN_TERMS    = 9;
  localparam int          NEWTON_STEPS = 16;
  localparam logic [3:0]  EXP_TERMS    = 4'd12;
  localparam int          SQUARINGS    = 3;

  // Truncating division of a QW-bit value by a small constant: multiply by
  // ceil(2^DIV_S / c) and shift; exact for every divisor up to 2^DIV_L.
  localparam int          DIV_L   = 9;
  localparam int          DIV_S   = QW + DIV_L;
  localparam int          MW      = QW + 7;
  localparam logic [63:0] DIV_ONE = 64'd1 << DIV_S;
  localparam logic [MW-1:0] SIN_DIV_M [SIN_TERMS] = '{
    MW'((DIV_ONE + 64'd5)   / 64'd6),
    MW'((DIV_ONE + 64'd19)  / 64'd20),
    MW'((DIV_ONE + 64'd41)  / 64'd42),
    MW'((DIV_ONE + 64'd71)  / 64'd72),
    MW'((DIV_ONE + 64'd109) / 64'd110),
    MW'((DIV_ONE + 64'd155) / 64'd156),
    MW'((DIV_ONE + 64'd209) / 64'd210),
    MW'((DIV_ONE + 64'd271) / 64'd272),
    MW'((DIV_ONE + 64'd341) / 64'd342)
  };

  // Same scheme for the exponential series, divisors 1 to 12
  localparam int          EXP_DIV_L = 4;
  localparam int          EXP_DIV_S = QW + EXP_DIV_L;
  localparam int          EMW       = QW + EXP_DIV_L + 1;
  localparam logic [63:0] EXP_ONE   = 64'd1 << EXP_DIV_S;
  localparam logic [EMW-1:0] EXP_DIV_M [int'(EXP_TERMS)] = '{
    EMW'(EXP_ONE),
    EMW'((EXP_ONE + 64'd1)  / 64'd2),
    EMW'((EXP_ONE + 64'd2)  / 64'd3),
    EMW'((EXP_ONE + 64'd3)  / 64'd4),
    EMW'((EXP_ONE + 64'd4)  / 64'd5),
    EMW'((EXP_ONE + 64'd5)  / 64'd6),
    EMW'((EXP_ONE + 64'd6)  / 64'd7),
    EMW'((EXP_ONE + 64'd7)  / 64'd8),
    EMW'((EXP_ONE + 64'd8)  / 64'd9),
    EMW'((EXP_ONE + 64'd9)  / 64'd10),
    EMW'((EXP_ONE + 64'd10) / 64'd11),
    EMW'((EXP_ONE + 64'd11) / 64'd12)
  };

  // Elevation limits and output scaling
  localparam logic [ELEV_W-2:0] CUTOFF_MDEG = 17'd5000;
  localparam logic [ELEV_W-2:0] MAX_MDEG    = 17'd90000;
  localparam logic [WET_W-1:0]  WET_DIV     = 14'd10000;
  localparam logic [WET_W-1:0]  WET_HALF    = 14'd5000;
  localparam logic [WET_W-1:0]  OUT_SCALE   = 14'd10000;
  localparam logic [SLANT_W-1:0] OUT_MAX    = 19'h7FFFF;

  // Wet term as w*WET_Q_INT + (w*WET_Q_REM + half) / 10000; the division is a
  // reciprocal multiply, exact for dividends below 2^WD_W
  localparam logic [QW-1:0]    WET_Q_INT = QW'((64'd1 << FRAC_BITS) / 64'(WET_DIV));
  localparam logic [WET_W-1:0] WET_Q_REM = WET_W'((64'd1 << FRAC_BITS) % 64'(WET_DIV));
  localparam int               WD_W      = 2 * WET_W;
  localparam int               WD_S      = WD_W + WET_W;
  localparam logic [WD_W:0]    WET_DIV_M =
    (WD_W+1)'(((64'd1 << WD_S) + 64'(WET_DIV) - 64'd1) / 64'(WET_DIV));

  // Control that travels with each pipeline beat
  typedef struct packed {
    logic valid;
    logic cut;
  } tdem_ctl_t;

  // Product of two fixed-point values, rounded half up
  function automatic logic [QW-1:0] qmul(input logic [QW-1:0] a, input logic [QW-1:0] b);
    logic [PW-1:0] p;
    p = PW'(a) * PW'(b) + (PW'(1) << (FRAC_BITS - 1));
    return p[FRAC_BITS +: QW];
  endfunction

endpackage

FILE: design/tdem_zen.sv
module tdem_zen (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          restart,
  input  logic [tdem_pkg::HEIGHT_W-1:0] height,
  input  logic [tdem_pkg::WET_W-1:0]    wet,
  output logic [tdem_pkg::QW-1:0]       zen_scaled,
  output logic                          busy
);
  import tdem_pkg::*;

  typedef enum logic [2:0] {
    ST_INIT, ST_EMUL, ST_EDIV, ST_SQ, ST_DRY, ST_WDIV, ST_ZEN, ST_DONE
  } state_t;

  localparam int EPW = QW + EMW;
  localparam int WPW = 2 * WD_W + 1;

  state_t            state_r;
  logic [QW-1:0]     term_r, sum_r, acc_r, zs_r, num_r, wint_r;
  logic [3:0]        k_r;
  logic [1:0]        sq_r;
  logic [WD_W-1:0]   wrem_r;

  logic                neg_exp;
  logic [HEIGHT_W-1:0] mag;
  logic [QW-1:0]       y_q, exp_prod, sq_prod, dry_prod, zs_prod, quo_q, sum_sub;
  logic [QW-1:0]       wquo_q;
  logic [EPW-1:0]      eprod;
  logic [WPW-1:0]      wprod;

  // Exponent argument |h| * 0.0000145; positive height gives a decaying series
  assign neg_exp  = !height[HEIGHT_W-1];
  assign mag      = height[HEIGHT_W-1] ? (~height + 1'b1) : height;
  assign y_q      = QW'(QW'(mag) * EXP8_Q);

  assign exp_prod = qmul(term_r, y_q);
  assign sq_prod  = qmul(sum_r, sum_r);
  assign dry_prod = qmul(DRY_Q, sum_r);
  assign zs_prod  = qmul(acc_r, SCALE_Q);

  // Series term divided by its index: reciprocal multiply
  assign eprod    = EPW'(num_r) * EPW'(EXP_DIV_M[k_r - 4'd1]);
  assign quo_q    = eprod[EXP_DIV_S +: QW];
  assign sum_sub  = (sum_r >= quo_q) ? (sum_r - quo_q) : '0;

  // Wet remainder part divided by 10000
  assign wprod    = WPW'(wrem_r) * WPW'(WET_DIV_M);
  assign wquo_q   = QW'(wprod[WPW-1:WD_S]);

  // Sequencer: Taylor series, squarings, dry scale, wet add, mapping scale
  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      state_r <= ST_INIT;
    end else begin
      unique case (state_r)
        ST_INIT: begin
          term_r  <= ONE_Q;
          sum_r   <= ONE_Q;
          k_r     <= 4'd1;
          state_r <= ST_EMUL;
        end
        ST_EMUL: begin
          num_r   <= exp_prod;
          state_r <= ST_EDIV;
        end
        ST_EDIV: begin
          term_r <= quo_q;
          sum_r  <= (neg_exp && k_r[0]) ? sum_sub : (sum_r + quo_q);
          if (k_r == EXP_TERMS) begin
            sq_r    <= '0;
            state_r <= ST_SQ;
          end else begin
            k_r     <= k_r + 1'b1;
            state_r <= ST_EMUL;
          end
        end
        ST_SQ: begin
          sum_r <= sq_prod;
          if (sq_r == 2'(SQUARINGS - 1)) begin
            state_r <= ST_DRY;
          end else begin
            sq_r <= sq_r + 1'b1;
          end
        end
        ST_DRY: begin
          acc_r   <= dry_prod;
          wint_r  <= QW'(QW'(wet) * WET_Q_INT);
          wrem_r  <= WD_W'(WD_W'(wet) * WD_W'(WET_Q_REM)) + WD_W'(WET_HALF);
          state_r <= ST_WDIV;
        end
        ST_WDIV: begin
          acc_r   <= acc_r + wint_r + wquo_q;
          state_r <= ST_ZEN;
        end
        ST_ZEN: begin
          zs_r    <= zs_prod;
          state_r <= ST_DONE;
        end
        ST_DONE: begin
          state_r <= ST_DONE;
        end
      endcase
    end
  end

  assign zen_scaled = zs_r;
  assign busy       = (state_r != ST_DONE);

endmodule

FILE: design/tdem_sine.sv
module tdem_sine (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    adv,
  input  tdem_pkg::tdem_ctl_t     in_ctl,
  input  logic [tdem_pkg::QW-1:0] in_x,
  output tdem_pkg::tdem_ctl_t     out_ctl,
  output logic [tdem_pkg::QW-1:0] out_s
);
  import tdem_pkg::*;

  localparam int DPW = DIV_S + QW;

  tdem_ctl_t     bd_ctl  [SIN_TERMS+1];
  logic [QW-1:0] bd_x    [SIN_TERMS+1];
  logic [QW-1:0] bd_term [SIN_TERMS+1];
  logic [QW-1:0] bd_sum  [SIN_TERMS+1];

  assign bd_ctl[0]  = in_ctl;
  assign bd_x[0]    = in_x;
  assign bd_term[0] = in_x;
  assign bd_sum[0]  = in_x;

  // One series term per three stages: term*x, *x, divide by (2k)(2k+1)
  for (genvar i = 0; i < SIN_TERMS; i++) begin : g_term
    localparam bit SUB = (i % 2) == 0;

    tdem_ctl_t     a_ctl_r, b_ctl_r, c_ctl_r;
    logic [QW-1:0] a_x_r, a_sum_r, a_p_r;
    logic [QW-1:0] b_x_r, b_sum_r, b_p_r;
    logic [QW-1:0] c_x_r, c_term_r, c_sum_r;
    logic [DPW-1:0] div_prod;
    logic [QW-1:0]  quo, sum_nxt;

    assign div_prod = DPW'(b_p_r) * DPW'(SIN_DIV_M[i]);
    assign quo      = div_prod[DIV_S +: QW];
    assign sum_nxt  = SUB ? ((b_sum_r >= quo) ? (b_sum_r - quo) : '0)
                          : (b_sum_r + quo);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        a_ctl_r <= '0;
        b_ctl_r <= '0;
        c_ctl_r <= '0;
      end else if (adv) begin
        a_ctl_r <= bd_ctl[i];
        b_ctl_r <= a_ctl_r;
        c_ctl_r <= b_ctl_r;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        a_x_r    <= bd_x[i];
        a_sum_r  <= bd_sum[i];
        a_p_r    <= qmul(bd_term[i], bd_x[i]);
        b_x_r    <= a_x_r;
        b_sum_r  <= a_sum_r;
        b_p_r    <= qmul(a_p_r, a_x_r);
        c_x_r    <= b_x_r;
        c_term_r <= quo;
        c_sum_r  <= sum_nxt;
      end
    end

    assign bd_ctl[i+1]  = c_ctl_r;
    assign bd_x[i+1]    = c_x_r;
    assign bd_term[i+1] = c_term_r;
    assign bd_sum[i+1]  = c_sum_r;
  end

  assign out_ctl = bd_ctl[SIN_TERMS];
  assign out_s   = bd_sum[SIN_TERMS];

endmodule

FILE: design/tdem_rsqrt.sv
module tdem_rsqrt (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    adv,
  input  tdem_pkg::tdem_ctl_t     in_ctl,
  input  logic [tdem_pkg::QW-1:0] in_d,
  output tdem_pkg::tdem_ctl_t     out_ctl,
  output logic [tdem_pkg::QW-1:0] out_y
);
  import tdem_pkg::*;

  tdem_ctl_t     bd_ctl [NEWTON_STEPS+1];
  logic [QW-1:0] bd_d   [NEWTON_STEPS+1];
  logic [QW-1:0] bd_y   [NEWTON_STEPS+1];

  assign bd_ctl[0] = in_ctl;
  assign bd_d[0]   = in_d;
  assign bd_y[0]   = ONE_Q;

  // Newton step y*(3 - d*y*y)/2 over three stages
  for (genvar i = 0; i < NEWTON_STEPS; i++) begin : g_step
    tdem_ctl_t     a_ctl_r, b_ctl_r, c_ctl_r;
    logic [QW-1:0] a_d_r, a_y_r, a_yy_r;
    logic [QW-1:0] b_d_r, b_y_r, b_diff_r;
    logic [QW-1:0] c_d_r, c_y_r;
    logic [QW-1:0] t, t_sat, y_prod;

    assign t      = qmul(a_d_r, a_yy_r);
    assign t_sat  = (t > THREE_Q) ? THREE_Q : t;
    assign y_prod = qmul(b_y_r, b_diff_r);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        a_ctl_r <= '0;
        b_ctl_r <= '0;
        c_ctl_r <= '0;
      end else if (adv) begin
        a_ctl_r <= bd_ctl[i];
        b_ctl_r <= a_ctl_r;
        c_ctl_r <= b_ctl_r;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        a_d_r    <= bd_d[i];
        a_y_r    <= bd_y[i];
        a_yy_r   <= qmul(bd_y[i], bd_y[i]);
        b_d_r    <= a_d_r;
        b_y_r    <= a_y_r;
        b_diff_r <= THREE_Q - t_sat;
        c_d_r    <= b_d_r;
        c_y_r    <= y_prod >> 1;
      end
    end

    assign bd_ctl[i+1] = c_ctl_r;
    assign bd_d[i+1]   = c_d_r;
    assign bd_y[i+1]   = c_y_r;
  end

  assign out_ctl = bd_ctl[NEWTON_STEPS];
  assign out_y   = bd_y[NEWTON_STEPS];

endmodule

FILE: design/tropo_delay_elevation_mapping.sv
// Tropospheric slant delay: takes one satellite elevation (millidegrees) per beat
// and returns the delay in 0.1 mm, rounded and saturated at 524287, or zero with
// below_cutoff set under 5 degrees. One beat is accepted every clock while
// in_ready is high; the pipeline depth is set by the sine series (27 stages)
// and the inverse square root Newton steps (48 stages) plus five stages of
// setup and scaling and the output register, and all of it holds while the
// skid slot is full. The zenith delay is worked out by a small sequencer after
// reset and after every configuration write; in_ready stays low in the write
// cycle and while the sequencer runs (and likewise after reset).
module tropo_delay_elevation_mapping (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [tdem_pkg::ELEV_W-1:0]   in_elevation_mdeg,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [tdem_pkg::SLANT_W-1:0]         out_slant_delay,
  output logic                                 out_below_cutoff,
  input  logic                                 cfg_we,
  input  logic [0:0]                           cfg_index,
  input  logic [tdem_pkg::CFG_W-1:0]           cfg_wdata
);
  import tdem_pkg::*;

  localparam int RW = QW + WET_W - FRAC_BITS;

  logic [HEIGHT_W-1:0] height_r;
  logic [WET_W-1:0]    wet_r;
  logic                zen_busy;
  logic [QW-1:0]       zen_scaled;
  logic                adv;

  tdem_ctl_t           s0_ctl_r, s1_ctl_r, d_ctl_r, f1_ctl_r, f2_ctl_r;
  logic [ELEV_W-2:0]   s0_elev_r;
  logic [QW-1:0]       s1_x_r, d_r, f1_slant_r;
  logic [SLANT_W-1:0]  f2_slant_r;
  tdem_ctl_t           sin_ctl, rs_ctl;
  logic [QW-1:0]       sin_s, rs_y;
  logic                in_cut;
  logic [ELEV_W-2:0]   in_elev;
  logic [QW+WET_W-1:0] out_prod;
  logic [RW-1:0]       out_round;
  logic [SLANT_W-1:0]  out_sat;

  logic                out_valid_r, out_cut_r, skid_valid_r, skid_cut_r;
  logic [SLANT_W-1:0]  out_slant_r, skid_slant_r;
  logic                push, pop;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      height_r <= '0;
      wet_r    <= 14'd1000;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_HEIGHT: height_r <= cfg_wdata[HEIGHT_W-1:0];
        REG_WET:    wet_r    <= cfg_wdata[WET_W-1:0];
        default:    ;
      endcase
    end
  end

  tdem_zen u_zen (
    .clk        (clk),
    .rst_n      (rst_n),
    .restart    (cfg_we),
    .height     (height_r),
    .wet        (wet_r),
    .zen_scaled (zen_scaled),
    .busy       (zen_busy)
  );

  // Whole pipeline moves while the skid slot is free
  assign adv      = !skid_valid_r;
  assign in_ready = adv && !zen_busy && !cfg_we;

  // Cutoff test and clamp at zenith
  assign in_cut  = in_elevation_mdeg[ELEV_W-1] ||
                   (in_elevation_mdeg[ELEV_W-2:0] < CUTOFF_MDEG);
  assign in_elev = (in_elevation_mdeg[ELEV_W-2:0] > MAX_MDEG) ? MAX_MDEG
                                                              : in_elevation_mdeg[ELEV_W-2:0];

  // Final scaling to 0.1 mm with rounding and saturation
  assign out_prod  = (QW+WET_W)'(f1_slant_r) * (QW+WET_W)'(OUT_SCALE)
                   + ((QW+WET_W)'(1) << (FRAC_BITS - 1));
  assign out_round = out_prod[QW+WET_W-1:FRAC_BITS];
  assign out_sat   = (out_round > RW'(OUT_MAX)) ? OUT_MAX : out_round[SLANT_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_ctl_r <= '0;
      s1_ctl_r <= '0;
      d_ctl_r  <= '0;
      f1_ctl_r <= '0;
      f2_ctl_r <= '0;
    end else if (adv) begin
      s0_ctl_r <= '{valid: in_valid && in_ready, cut: in_cut};
      s1_ctl_r <= s0_ctl_r;
      d_ctl_r  <= sin_ctl;
      f1_ctl_r <= rs_ctl;
      f2_ctl_r <= f1_ctl_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_elev_r  <= in_elev;
      s1_x_r     <= QW'(QW'(s0_elev_r) * RAD_Q);
      d_r        <= qmul(sin_s, sin_s) + BIAS_Q;
      f1_slant_r <= qmul(zen_scaled, rs_y);
      f2_slant_r <= f1_ctl_r.cut ? '0 : out_sat;
    end
  end

  tdem_sine u_sine (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .in_ctl  (s1_ctl_r),
    .in_x    (s1_x_r),
    .out_ctl (sin_ctl),
    .out_s   (sin_s)
  );

  tdem_rsqrt u_rsqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .in_ctl  (d_ctl_r),
    .in_d    (d_r),
    .out_ctl (rs_ctl),
    .out_y   (rs_y)
  );

  // Output register with one skid slot
  assign push = adv && f2_ctl_r.valid;
  assign pop  = out_valid_r && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (pop) begin
        out_slant_r  <= skid_slant_r;
        out_cut_r    <= skid_cut_r;
        skid_valid_r <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid_r || pop) begin
        out_slant_r <= f2_slant_r;
        out_cut_r   <= f2_ctl_r.cut;
        out_valid_r <= 1'b1;
      end else begin
        skid_slant_r <= f2_slant_r;
        skid_cut_r   <= f2_ctl_r.cut;
        skid_valid_r <= 1'b1;
      end
    end else if (pop) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_slant_delay  = out_slant_r;
  assign out_below_cutoff = out_cut_r;

`ifndef SYNTHESIS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid slot holds a beat while the output register is empty");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    zen_busy |-> !in_ready)
    else $error("input accepted while zenith delay is being computed");

  a_cut_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_below_cutoff) |-> (out_slant_delay == '0))
    else $error("cutoff beat carries a nonzero delay");

  a_cfg_restart: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> zen_busy)
    else $error("configuration write did not restart zenith computation");
`endif

endmodule
